// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros for the dispense sequencer checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BSDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define BSDS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/bsds_pkg.sv
// ----------------------------------------------------------------------------
// bsds_pkg
// types and constants of the burst/salvo dispense sequencer
// ----------------------------------------------------------------------------
package bsds_pkg;

  localparam int QTY_W   = 7;
  localparam int TIME_W  = 16;
  localparam int STOCK_W = 8;
  localparam int SALVO_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // command codes carried in the mode field
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHAFF_BURST_QTY      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAFF_BURST_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAFF_SALVO_QTY      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAFF_SALVO_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLARE_BURST_QTY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLARE_BURST_INTERVAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLARE_SALVO_QTY      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FLARE_SALVO_INTERVAL = 3'd7;

  // register reset values
  localparam logic [QTY_W-1:0]  RST_BURST_QTY      = 7'd1;
  localparam logic [TIME_W-1:0] RST_BURST_INTERVAL = 16'd20;
  localparam logic [QTY_W-1:0]  RST_SALVO_QTY      = 7'd1;
  localparam logic [TIME_W-1:0] RST_SALVO_INTERVAL = 16'd100;

  typedef struct packed {
    logic [1:0]         mode;
    logic               rwr_present;
    logic               rwr_on;
    logic               chaff_power;
    logic               flare_power;
    logic               bus_fault;
    logic [STOCK_W-1:0] chaff_load;
    logic [STOCK_W-1:0] flare_load;
  } in_t;

  typedef struct packed {
    logic               chaff_released;
    logic               flare_released;
    logic               program_active;
    logic [STOCK_W-1:0] chaff_left;
    logic [STOCK_W-1:0] flare_left;
  } out_t;

  typedef struct packed {
    logic [QTY_W-1:0]  burst_qty;
    logic [TIME_W-1:0] burst_interval;
    logic [QTY_W-1:0]  salvo_qty;
    logic [TIME_W-1:0] salvo_interval;
  } chan_cfg_t;

  // per-channel command for one accepted transfer
  typedef struct packed {
    logic               start;
    logic               tick;
    logic               load;
    logic               may_release;
    logic [STOCK_W-1:0] load_value;
  } chan_cmd_t;

  // per-channel status for the same transfer
  typedef struct packed {
    logic               released;
    logic               finished;
    logic [STOCK_W-1:0] stock_next;
  } chan_stat_t;

endpackage

// File: design/burst_salvo_dispense_sequencer.sv
// ----------------------------------------------------------------------------
// burst_salvo_dispense_sequencer
// two-channel chaff/flare dispenser running one burst/salvo release program
// ----------------------------------------------------------------------------
// One command per input transfer: load inventory, start a program, or one
// program tick. Every input transfer produces exactly one result transfer
// carrying the release flags, the program state and the remaining stock
// after that command. Each command is decided in the cycle it is taken: the
// channel counters update at the input edge and the result lands in a single
// output register, so the block sustains one transfer per clock. The only
// thing that holds the input back is a full output register that the
// consumer is not taking (in_ready = !out_valid || out_ready). Configuration
// writes take effect on the next edge and have no read-back.
module burst_salvo_dispense_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bsds_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bsds_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [bsds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsds_pkg::CFG_DATA_W-1:0] cfg_data
);

  bsds_pkg::chan_cfg_t  chaff_cfg, flare_cfg;
  bsds_pkg::chan_cmd_t  chaff_cmd, flare_cmd;
  bsds_pkg::chan_stat_t chaff_stat, flare_stat;

  logic active, active_next;
  logic accept;
  logic is_tick, is_start, is_load;
  logic release_ok;

  // output register frees up in the same cycle it is taken
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  bsds_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chaff_cfg (chaff_cfg),
    .flare_cfg (flare_cfg)
  );

  always_comb begin
    // a tick only runs with the program active and the receiver fitted;
    // mode 3 decodes to nothing
    is_load    = (in_data.mode == bsds_pkg::MODE_LOAD);
    is_start   = (in_data.mode == bsds_pkg::MODE_START);
    is_tick    = (in_data.mode == bsds_pkg::MODE_TICK) && in_data.rwr_present && active;
    release_ok = in_data.rwr_on && !in_data.bus_fault;

    chaff_cmd.load        = is_load;
    chaff_cmd.start       = is_start;
    chaff_cmd.tick        = is_tick;
    chaff_cmd.may_release = release_ok && in_data.chaff_power;
    chaff_cmd.load_value  = in_data.chaff_load;

    flare_cmd.load        = is_load;
    flare_cmd.start       = is_start;
    flare_cmd.tick        = is_tick;
    flare_cmd.may_release = release_ok && in_data.flare_power;
    flare_cmd.load_value  = in_data.flare_load;

    // program ends once both channels have run out of bursts and salvos
    active_next = active;
    if (is_start) begin
      active_next = 1'b1;
    end else if (is_tick && chaff_stat.finished && flare_stat.finished) begin
      active_next = 1'b0;
    end
  end

  bsds_chan u_chaff (
    .clk  (clk),
    .rst  (rst),
    .en   (accept),
    .cfg  (chaff_cfg),
    .cmd  (chaff_cmd),
    .stat (chaff_stat)
  );

  bsds_chan u_flare (
    .clk  (clk),
    .rst  (rst),
    .en   (accept),
    .cfg  (flare_cfg),
    .cmd  (flare_cmd),
    .stat (flare_stat)
  );

  // program flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      active <= active_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.chaff_released <= chaff_stat.released;
      out_data.flare_released <= flare_stat.released;
      out_data.program_active <= active_next;
      out_data.chaff_left     <= chaff_stat.stock_next;
      out_data.flare_left     <= flare_stat.stock_next;
    end
  end

endmodule

// File: design/bsds_cfg.sv
// ----------------------------------------------------------------------------
// bsds_cfg
// configuration register file, one set of four registers per channel
// ----------------------------------------------------------------------------
module bsds_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bsds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsds_pkg::CFG_DATA_W-1:0]     cfg_data,
  output bsds_pkg::chan_cfg_t                 chaff_cfg,
  output bsds_pkg::chan_cfg_t                 flare_cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      chaff_cfg.burst_qty      <= bsds_pkg::RST_BURST_QTY;
      chaff_cfg.burst_interval <= bsds_pkg::RST_BURST_INTERVAL;
      chaff_cfg.salvo_qty      <= bsds_pkg::RST_SALVO_QTY;
      chaff_cfg.salvo_interval <= bsds_pkg::RST_SALVO_INTERVAL;
      flare_cfg.burst_qty      <= bsds_pkg::RST_BURST_QTY;
      flare_cfg.burst_interval <= bsds_pkg::RST_BURST_INTERVAL;
      flare_cfg.salvo_qty      <= bsds_pkg::RST_SALVO_QTY;
      flare_cfg.salvo_interval <= bsds_pkg::RST_SALVO_INTERVAL;
    end else if (cfg_we) begin
      case (cfg_index)
        bsds_pkg::REG_CHAFF_BURST_QTY:
          chaff_cfg.burst_qty <= cfg_data[bsds_pkg::QTY_W-1:0];
        bsds_pkg::REG_CHAFF_BURST_INTERVAL:
          chaff_cfg.burst_interval <= cfg_data[bsds_pkg::TIME_W-1:0];
        bsds_pkg::REG_CHAFF_SALVO_QTY:
          chaff_cfg.salvo_qty <= cfg_data[bsds_pkg::QTY_W-1:0];
        bsds_pkg::REG_CHAFF_SALVO_INTERVAL:
          chaff_cfg.salvo_interval <= cfg_data[bsds_pkg::TIME_W-1:0];
        bsds_pkg::REG_FLARE_BURST_QTY:
          flare_cfg.burst_qty <= cfg_data[bsds_pkg::QTY_W-1:0];
        bsds_pkg::REG_FLARE_BURST_INTERVAL:
          flare_cfg.burst_interval <= cfg_data[bsds_pkg::TIME_W-1:0];
        bsds_pkg::REG_FLARE_SALVO_QTY:
          flare_cfg.salvo_qty <= cfg_data[bsds_pkg::QTY_W-1:0];
        bsds_pkg::REG_FLARE_SALVO_INTERVAL:
          flare_cfg.salvo_interval <= cfg_data[bsds_pkg::TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/bsds_chan.sv
// ----------------------------------------------------------------------------
// bsds_chan
// one dispenser channel: wait countdown, burst and salvo counters, stock
// ----------------------------------------------------------------------------
module bsds_chan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  bsds_pkg::chan_cfg_t  cfg,
  input  bsds_pkg::chan_cmd_t  cmd,
  output bsds_pkg::chan_stat_t stat
);

  logic [bsds_pkg::TIME_W-1:0]  wait_cnt, wait_cnt_next;
  logic [bsds_pkg::QTY_W-1:0]   burst_done, burst_done_next;
  logic [bsds_pkg::SALVO_W-1:0] salvos_left, salvos_left_next;
  logic                         rearmed, rearmed_next;
  logic [bsds_pkg::STOCK_W-1:0] stock, stock_next;

  logic [bsds_pkg::TIME_W-1:0]  w_dec, w_arm;
  logic [bsds_pkg::QTY_W-1:0]   bd_arm, bd_rel;
  logic [bsds_pkg::SALVO_W-1:0] sl_arm;
  logic                         ra_arm;
  logic                         do_rearm, due, fire, give;
  logic                         sl_pos, sl_nonpos;

  always_comb begin
    // countdown stops at zero
    w_dec  = (wait_cnt != '0) ? wait_cnt - 1'b1 : wait_cnt;

    // rearm for the next salvo
    sl_pos   = !salvos_left[bsds_pkg::SALVO_W-1] && (salvos_left != '0);
    do_rearm = (burst_done >= cfg.burst_qty) && sl_pos && !rearmed;
    w_arm    = do_rearm ? cfg.salvo_interval : w_dec;
    bd_arm   = do_rearm ? '0 : burst_done;
    sl_arm   = do_rearm ? salvos_left - 1'b1 : salvos_left;
    ra_arm   = do_rearm ? 1'b1 : rearmed;

    // release attempt
    due    = (w_arm == '0) && (bd_arm < cfg.burst_qty);
    fire   = due && cmd.may_release;
    give   = fire && (stock != '0);
    bd_rel = fire ? bd_arm + 1'b1 : bd_arm;

    wait_cnt_next    = wait_cnt;
    burst_done_next  = burst_done;
    salvos_left_next = salvos_left;
    rearmed_next     = rearmed;
    stock_next       = stock;

    if (cmd.load) begin
      stock_next = cmd.load_value;
    end else if (cmd.start) begin
      burst_done_next  = '0;
      wait_cnt_next    = cfg.burst_interval;
      salvos_left_next = {1'b0, cfg.salvo_qty} - 1'b1;
    end else if (cmd.tick) begin
      wait_cnt_next    = fire ? cfg.burst_interval : w_arm;
      burst_done_next  = bd_rel;
      salvos_left_next = sl_arm;
      rearmed_next     = due ? 1'b0 : ra_arm;
      stock_next       = give ? stock - 1'b1 : stock;
    end

    sl_nonpos = salvos_left_next[bsds_pkg::SALVO_W-1] || (salvos_left_next == '0);

    stat.released   = cmd.tick && give;
    stat.finished   = (burst_done_next >= cfg.burst_qty) && sl_nonpos;
    stat.stock_next = stock_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_cnt    <= '0;
      burst_done  <= '0;
      salvos_left <= '0;
      rearmed     <= 1'b0;
      stock       <= '0;
    end else if (en) begin
      wait_cnt    <= wait_cnt_next;
      burst_done  <= burst_done_next;
      salvos_left <= salvos_left_next;
      rearmed     <= rearmed_next;
      stock       <= stock_next;
    end
  end

endmodule

// File: design/bsds_checker.sv
// ----------------------------------------------------------------------------
// bsds_checker
// port-level checks of the dispense sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsds_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input bsds_pkg::in_t                   in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input bsds_pkg::out_t                  out_data,
  input logic                            cfg_we,
  input logic [bsds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [bsds_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                             in_xfer;
  logic                             load_xfer, start_xfer;
  logic [2*bsds_pkg::STOCK_W-1:0]   last_load;
  logic                             load_match, start_quiet, cfg_quiet;

  assign in_xfer     = in_valid && in_ready;
  assign load_xfer   = in_xfer && (in_data.mode == bsds_pkg::MODE_LOAD);
  assign start_xfer  = in_xfer && (in_data.mode == bsds_pkg::MODE_START);
  assign load_match  = out_valid &&
                       ({out_data.chaff_left, out_data.flare_left} == last_load);
  assign start_quiet = out_data.program_active && !out_data.chaff_released &&
                       !out_data.flare_released;
  assign cfg_quiet   = !in_valid && !out_valid && !$isunknown({cfg_index, cfg_data});

  // load values seen on the previous edge
  always_ff @(posedge clk) begin
    last_load <= {in_data.chaff_load, in_data.flare_load};
  end

  // a pending result is never dropped
  `BSDS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // input only stalls behind a held result
  `BSDS_ASSERT_IMP(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready)

  // a load shows the loaded stock right away
  `BSDS_ASSERT_NXT(a_load_stock, clk, rst, load_xfer, load_match)

  // a start always reports a running program and never releases
  `BSDS_ASSERT_NXT(a_start_active, clk, rst, start_xfer, start_quiet)

  // register writes only land with nothing in flight
  `BSDS_ASSERT_IMP(a_cfg_quiet, clk, rst, cfg_we, cfg_quiet)

endmodule

bind burst_salvo_dispense_sequencer bsds_checker u_bsds_checker (.*);
